// ===== rtl/tlv_frame_deframer_assert.svh =====
// Assertion macros used by the checker file.
`ifndef TLV_FRAME_DEFRAMER_ASSERT_SVH
`define TLV_FRAME_DEFRAMER_ASSERT_SVH

// Clocked property, held off while reset is asserted.
`define TLVD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked through reset.
`define TLVD_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tlvd_pkg.sv =====
package tlvd_pkg;

  localparam int unsigned TYPE_W     = 8;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TYPE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 4'd1;

  localparam logic [TYPE_W-1:0] MAX_TYPE_RST    = 8'd5;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 16'd512;

  // Header bytes held before the third one completes a candidate
  localparam logic [1:0] HDR_FILL_FULL = 2'd2;

  typedef struct packed {
    logic [TYPE_W-1:0] frame_type;
    logic [BYTE_W-1:0] payload_byte;
    logic              byte_present;
    logic [LEN_W-1:0]  byte_index;
    logic [LEN_W-1:0]  payload_length;
    logic              frame_end;
  } tlvd_result_t;

endpackage

// ===== rtl/tlvd_if.sv =====
interface tlvd_in_if import tlvd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tlvd_out_if import tlvd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] frame_type;
  logic [BYTE_W-1:0] payload_byte;
  logic              byte_present;
  logic [LEN_W-1:0]  byte_index;
  logic [LEN_W-1:0]  payload_length;
  logic              frame_end;

  modport source (output valid, output frame_type, output payload_byte,
                  output byte_present, output byte_index, output payload_length,
                  output frame_end, input ready);
  modport sink (input valid, input frame_type, input payload_byte,
                input byte_present, input byte_index, input payload_length,
                input frame_end, output ready);
endinterface

interface tlvd_cfg_if import tlvd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tlvd_core.sv =====
module tlvd_core import tlvd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [TYPE_W-1:0] max_type,
  input  logic [LEN_W-1:0]  max_payload,
  output logic              res_valid,
  output tlvd_result_t      res
);

  logic [BYTE_W-1:0] pend0_r, pend0_nxt;
  logic [BYTE_W-1:0] pend1_r, pend1_nxt;
  logic [1:0]        fill_r, fill_nxt;
  logic              in_payload_r, in_payload_nxt;
  logic [TYPE_W-1:0] cur_type_r, cur_type_nxt;
  logic [LEN_W-1:0]  cur_len_r, cur_len_nxt;
  logic [LEN_W-1:0]  seen_r, seen_nxt;

  logic [LEN_W-1:0]  hdr_len;
  logic              last_byte;

  // length arrives low byte first
  assign hdr_len   = {rx_byte, pend1_r};
  assign last_byte = ({1'b0, seen_r} + 17'd1) >= {1'b0, cur_len_r};

  always_comb begin
    pend0_nxt      = pend0_r;
    pend1_nxt      = pend1_r;
    fill_nxt       = fill_r;
    in_payload_nxt = in_payload_r;
    cur_type_nxt   = cur_type_r;
    cur_len_nxt    = cur_len_r;
    seen_nxt       = seen_r;
    res_valid      = 1'b0;
    res            = '0;
    if (fire) begin
      if (in_payload_r) begin
        res_valid          = 1'b1;
        res.frame_type     = cur_type_r;
        res.payload_byte   = rx_byte;
        res.byte_present   = 1'b1;
        res.byte_index     = seen_r;
        res.payload_length = cur_len_r;
        res.frame_end      = last_byte;
        seen_nxt           = last_byte ? '0 : seen_r + 16'd1;
        in_payload_nxt     = !last_byte;
      end else if (fill_r < HDR_FILL_FULL) begin
        if (fill_r[0]) begin
          pend1_nxt = rx_byte;
        end else begin
          pend0_nxt = rx_byte;
        end
        fill_nxt = fill_r + 2'd1;
      end else begin
        fill_nxt = HDR_FILL_FULL;
        if ((pend0_r > max_type) || (hdr_len > max_payload)) begin
          // slide one byte and retry
          pend0_nxt = pend1_r;
          pend1_nxt = rx_byte;
        end else begin
          fill_nxt     = '0;
          cur_type_nxt = pend0_r;
          cur_len_nxt  = hdr_len;
          seen_nxt     = '0;
          if (hdr_len == '0) begin
            res_valid      = 1'b1;
            res.frame_type = pend0_r;
            res.frame_end  = 1'b1;
          end else begin
            in_payload_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend0_r      <= '0;
      pend1_r      <= '0;
      fill_r       <= '0;
      in_payload_r <= 1'b0;
      cur_type_r   <= '0;
      cur_len_r    <= '0;
      seen_r       <= '0;
    end else begin
      pend0_r      <= pend0_nxt;
      pend1_r      <= pend1_nxt;
      fill_r       <= fill_nxt;
      in_payload_r <= in_payload_nxt;
      cur_type_r   <= cur_type_nxt;
      cur_len_r    <= cur_len_nxt;
      seen_r       <= seen_nxt;
    end
  end

endmodule

// ===== rtl/tlvd_out_buf.sv =====
module tlvd_out_buf import tlvd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         res_valid,
  input  tlvd_result_t res,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output tlvd_result_t out_data
);

  logic         out_valid_r;
  tlvd_result_t out_data_r;
  logic         skid_valid_r;
  tlvd_result_t skid_data_r;
  logic         out_fire;

  assign out_fire  = out_valid_r && out_ready;
  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // drain the skid stage first
      if (out_fire) begin
        out_valid_r  <= 1'b1;
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_fire) begin
      out_valid_r <= res_valid;
      out_data_r  <= res;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
      skid_data_r  <= res;
    end
  end

endmodule

// ===== rtl/tlv_frame_deframer.sv =====
// Type-length-value deframer, one received byte per word.
// in_ch carries rx_byte; a frame is a type byte, a little-endian 16-bit
// payload length and the payload. A header whose type is above max_type or
// whose length is above max_payload is rejected: drop its first byte and
// test the next three, so the block slides until it finds a good header.
// out_ch gives one word per payload byte with type, index, length and an end
// flag; a zero-length frame gives a single word with byte_present low.
// Other header bytes give no word. cfg_ch writes max_type (index 0) and
// max_payload (index 1) and is always ready; write it only while idle.
// Each result is registered before it shows on out_ch.
// Throughput: one byte per cycle while in_ch ready is high, set by the
// combinational header/payload decode between the state and output registers.
// Reset (rst_n low, synchronous): header collection and any frame in flight
// are dropped, max_type returns to 5, max_payload to 512, out_ch empties.
// Receiver stall: the output register and one skid word absorb it; in_ch
// ready drops only once both are full, and no word is lost.
module tlv_frame_deframer import tlvd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tlvd_in_if.sink   in_ch,
  tlvd_out_if.source out_ch,
  tlvd_cfg_if.sink  cfg_ch
);

  logic [TYPE_W-1:0] max_type_r;
  logic [LEN_W-1:0]  max_payload_r;

  logic              in_ready;
  logic              in_fire;
  logic              res_valid;
  tlvd_result_t      res;
  tlvd_result_t      out_data;

  // Configuration: always ready, write by index
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_type_r    <= MAX_TYPE_RST;
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MAX_TYPE:    max_type_r    <= cfg_ch.data[TYPE_W-1:0];
        REG_MAX_PAYLOAD: max_payload_r <= cfg_ch.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Accept a byte whenever the skid word is free
  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;

  tlvd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (in_fire),
    .rx_byte     (in_ch.rx_byte),
    .max_type    (max_type_r),
    .max_payload (max_payload_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  tlvd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .in_ready  (in_ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  // Unpack the held result onto the channel
  assign out_ch.frame_type     = out_data.frame_type;
  assign out_ch.payload_byte   = out_data.payload_byte;
  assign out_ch.byte_present   = out_data.byte_present;
  assign out_ch.byte_index     = out_data.byte_index;
  assign out_ch.payload_length = out_data.payload_length;
  assign out_ch.frame_end      = out_data.frame_end;

endmodule

// ===== rtl/tlvd_checker.sv =====
`include "tlv_frame_deframer_assert.svh"

module tlvd_checker import tlvd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_payload_byte,
  input logic              out_byte_present,
  input logic [LEN_W-1:0]  out_byte_index,
  input logic [LEN_W-1:0]  out_payload_length,
  input logic              out_frame_end
);

  `TLVD_ASSERT_NR(a_reset_empty, !rst_n |=> !out_valid, "output word after reset")

  `TLVD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_payload_byte) && $stable(out_byte_index), "stalled output word changed")

  `TLVD_ASSERT(a_stall_full, !in_ready |-> out_valid, "input stalled with empty output")

  `TLVD_ASSERT(a_empty_frame, out_valid && !out_byte_present |-> out_frame_end && out_payload_byte == 8'd0 && out_byte_index == 16'd0 && out_payload_length == 16'd0, "malformed empty frame word")

  `TLVD_ASSERT(a_byte_pos, out_valid && out_byte_present |-> out_byte_index < out_payload_length && out_frame_end == (({1'b0, out_byte_index} + 17'd1) == {1'b0, out_payload_length}), "byte index or end flag wrong")

endmodule

bind tlv_frame_deframer tlvd_checker u_tlvd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_payload_byte   (out_ch.payload_byte),
  .out_byte_present   (out_ch.byte_present),
  .out_byte_index     (out_ch.byte_index),
  .out_payload_length (out_ch.payload_length),
  .out_frame_end      (out_ch.frame_end)
);

// ===== tb/tb_tlv_frame_deframer.sv =====
module tb_tlv_frame_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import tlvd_pkg::*;

  // Hang detector: cycles in a row with no word moving on any channel.
  localparam int IDLE_LIMIT    = 1000;
  // Cycles to let the block settle after the last expected word.
  localparam int SETTLE_CYCLES = 4;

  // How a stimulus row is checked: by the predictor, as a header byte that
  // must give no word, or against a word typed into the table.
  typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_WORD} row_kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    row_kind_t         kind;
    tlvd_result_t      word;
  } stim_row_t;

  logic clk;
  logic rst_n;

  tlvd_in_if  in_ch ();
  tlvd_out_if out_ch ();
  tlvd_cfg_if cfg_ch ();

  tlv_frame_deframer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Deframer state as the testbench tracks it.
  logic [BYTE_W-1:0] hdr_byte [2] = '{8'h00, 8'h00};
  logic [1:0]        hdr_count    = 2'd0;
  logic              streaming    = 1'b0;
  logic [TYPE_W-1:0] frame_type_q = '0;
  logic [LEN_W-1:0]  frame_len_q  = '0;
  logic [LEN_W-1:0]  byte_count   = '0;
  logic [TYPE_W-1:0] lim_type     = MAX_TYPE_RST;
  logic [LEN_W-1:0]  lim_len      = MAX_PAYLOAD_RST;

  // Decoded words still owed by the block, oldest first.
  tlvd_result_t decoded_words [$];
  tlvd_result_t head_word;

  int mismatches    = 0;
  int bytes_sent    = 0;
  int words_checked = 0;
  int empty_frames  = 0;
  int settings_run  = 1;
  int idle_cycles   = 0;
  int in_burst      = 0;
  int out_burst     = 0;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic tlvd_result_t payload_word(input logic [TYPE_W-1:0] ty,
                                                input logic [BYTE_W-1:0] value,
                                                input logic present,
                                                input logic [LEN_W-1:0] idx,
                                                input logic [LEN_W-1:0] len,
                                                input logic last);
    return '{frame_type: ty, payload_byte: value, byte_present: present,
             byte_index: idx, payload_length: len, frame_end: last};
  endfunction

  // Advance the tracked state by one received byte; return 1 when the byte
  // gives a word.
  function automatic bit deframe_byte(input logic [BYTE_W-1:0] b,
                                      output tlvd_result_t word);
    logic [TYPE_W-1:0] cand_type;
    logic [LEN_W-1:0]  cand_len;
    logic              last;
    word = '0;
    if (streaming) begin
      last = ({1'b0, byte_count} + 17'd1) >= {1'b0, frame_len_q};
      word = payload_word(frame_type_q, b, 1'b1, byte_count, frame_len_q, last);
      byte_count = last ? '0 : byte_count + 16'd1;
      streaming  = !last;
      return 1'b1;
    end
    if (hdr_count < HDR_FILL_FULL) begin
      hdr_byte[hdr_count[0]] = b;
      hdr_count = hdr_count + 2'd1;
      return 1'b0;
    end
    cand_type = hdr_byte[0];
    cand_len  = {b, hdr_byte[1]};
    if (cand_type > lim_type || cand_len > lim_len) begin
      // Bad header: drop its first byte and try again from the second.
      hdr_byte[0] = hdr_byte[1];
      hdr_byte[1] = b;
      return 1'b0;
    end
    hdr_count    = '0;
    frame_type_q = cand_type;
    frame_len_q  = cand_len;
    byte_count   = '0;
    if (cand_len == '0) begin
      word = payload_word(cand_type, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b1);
      return 1'b1;
    end
    streaming = 1'b1;
    return 1'b0;
  endfunction

  // Draw the wait before the next word; now and then start a run with none.
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) burst = $urandom_range(8, 32);
    return $urandom_range(0, 3);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Offer one byte, hold it until accepted, then log what it should give.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input row_kind_t kind,
                           input tlvd_result_t typed);
    int           gap;
    bit           produced;
    tlvd_result_t word;
    gap = draw_wait(in_burst);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    produced = deframe_byte(b, word);
    case (kind)
      ROW_PREDICT: begin
        if (produced) decoded_words.push_back(word);
      end
      ROW_WORD: begin
        decoded_words.push_back(typed);
      end
      default: ;
    endcase
  endtask

  task automatic send_header(input int ty, input int len);
    send_byte(8'(ty), ROW_PREDICT, '0);
    send_byte(8'(len), ROW_PREDICT, '0);
    send_byte(8'(len >> 8), ROW_PREDICT, '0);
  endtask

  // Hold off until every owed word is out, then let header work finish.
  task automatic wait_drained();
    while (decoded_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_MAX_TYPE) lim_type = data[TYPE_W-1:0];
    else if (idx == REG_MAX_PAYLOAD) lim_len = data;
  endtask

  // One limit setting: mostly well-formed frames with random content, plus
  // rejected headers and stray bytes when noisy.
  task automatic run_phase(input int type_cap, input int len_cap, input bit noisy,
                           input int budget);
    int stop_at;
    int roll;
    int ty;
    int len;
    int n;
    wait_drained();
    // Upper data bits of the type register are junk the block must ignore.
    write_reg(REG_MAX_TYPE, {8'($urandom_range(0, 255)), 8'(type_cap)});
    write_reg(REG_MAX_PAYLOAD, 16'(len_cap));
    cfg_ch.valid <= 1'b0;
    settings_run++;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (!noisy || roll < 75) begin
        ty   = $urandom_range(0, type_cap);
        roll = $urandom_range(0, 9);
        if (roll == 0 && len_cap <= 40) len = len_cap;
        else if (roll == 1) len = $urandom_range(0, (len_cap < 300) ? len_cap : 300);
        else len = $urandom_range(0, (len_cap < 12) ? len_cap : 12);
        send_header(ty, len);
        repeat (len) send_byte(8'($urandom_range(0, 255)), ROW_PREDICT, '0);
      end else if (roll < 88) begin
        if (type_cap < 255 && (len_cap == 65535 || $urandom_range(0, 1) == 1)) begin
          ty  = $urandom_range(type_cap + 1, 255);
          len = $urandom_range(0, 65535);
        end else begin
          ty  = $urandom_range(0, type_cap);
          len = $urandom_range(len_cap + 1, 65535);
        end
        send_header(ty, len);
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom_range(0, 255)), ROW_PREDICT, '0);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  // Compare each word taken from the block against the oldest owed one.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (decoded_words.size() == 0) begin
        $error("word with nothing owed: frame_type 0x%0h byte_index %0d",
               out_ch.frame_type, out_ch.byte_index);
        mismatches++;
      end else begin
        head_word = decoded_words.pop_front();
        check_field("frame_type", 16'(head_word.frame_type), 16'(out_ch.frame_type));
        check_field("payload_byte", 16'(head_word.payload_byte),
                    16'(out_ch.payload_byte));
        check_field("byte_present", 16'(head_word.byte_present),
                    16'(out_ch.byte_present));
        check_field("byte_index", head_word.byte_index, out_ch.byte_index);
        check_field("payload_length", head_word.payload_length, out_ch.payload_length);
        check_field("frame_end", 16'(head_word.frame_end), 16'(out_ch.frame_end));
        words_checked++;
        if (!head_word.byte_present) empty_frames++;
      end
    end
  end

  // Bail out if no channel moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before each word.
  initial begin : receiver
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_wait(out_burst);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin : stimulus
    stim_row_t directed_rows [22];
    // Limits are at reset here: max type 5, max payload 512.
    directed_rows = '{
      // empty frame of type 0
      '{8'h00, ROW_SILENT, '0},
      '{8'h00, ROW_SILENT, '0},
      '{8'h00, ROW_WORD, payload_word(8'h00, 8'h00, 1'b0, 16'd0, 16'd0, 1'b1)},
      // highest allowed type, two payload bytes 0xAA and 0xFF
      '{8'h05, ROW_SILENT, '0},
      '{8'h02, ROW_SILENT, '0},
      '{8'h00, ROW_SILENT, '0},
      '{8'hAA, ROW_WORD, payload_word(8'h05, 8'hAA, 1'b1, 16'd0, 16'd2, 1'b0)},
      '{8'hFF, ROW_WORD, payload_word(8'h05, 8'hFF, 1'b1, 16'd1, 16'd2, 1'b1)},
      // type one above the limit; the slide lands on an empty frame
      '{8'h06, ROW_SILENT, '0},
      '{8'h00, ROW_SILENT, '0},
      '{8'h00, ROW_SILENT, '0},
      '{8'h00, ROW_WORD, payload_word(8'h00, 8'h00, 1'b0, 16'd0, 16'd0, 1'b1)},
      // length 513 rejected; the slide finds type 1 length 2
      '{8'h01, ROW_SILENT, '0},
      '{8'h01, ROW_SILENT, '0},
      '{8'h02, ROW_SILENT, '0},
      '{8'h00, ROW_PREDICT, '0},
      '{8'h00, ROW_PREDICT, '0},
      '{8'hFF, ROW_PREDICT, '0},
      // type 255 rejected, then an empty frame again
      '{8'hFF, ROW_SILENT, '0},
      '{8'h00, ROW_SILENT, '0},
      '{8'h00, ROW_SILENT, '0},
      '{8'h00, ROW_WORD, payload_word(8'h00, 8'h00, 1'b0, 16'd0, 16'd0, 1'b1)}
    };

    // Drive every input to a known value, then hold reset.
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.rx_byte  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= REG_MAX_TYPE;
    cfg_ch.data    <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].rx, directed_rows[i].kind, directed_rows[i].word);
    in_ch.valid <= 1'b0;

    // The table ends on a frame boundary, so the widest length limit is safe
    // here: no stray byte can open a frame tens of thousands of bytes long.
    run_phase(3, 65535, 1'b0, 220);
    run_phase(255, 16, 1'b1, 220);
    // Only the all-zero empty frame gets through.
    run_phase(0, 0, 1'b1, 200);
    run_phase(5, 512, 1'b1, 220);
    run_phase(7, 40, 1'b1, 220);
    run_phase(255, 1, 1'b1, 200);

    wait_drained();
    $display("Sent %0d stream bytes under %0d limit settings; checked %0d words,",
             bytes_sent, settings_run, words_checked);
    $display("%0d of them empty frames, with %0d mismatches.", empty_frames, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
